// File: hdl/pidc_pkg.sv
// Shared types and constants for the clamped PID controller.
package pidc_pkg;

  localparam int DataW = 32;
  localparam int LimW = 31;
  localparam int AccW = 72;
  localparam int CntW = 6;
  localparam logic [16:0] LeakNum = 17'd64881;
  localparam int LeakShift = 16;

  typedef enum logic [2:0] {
    RegPropGain  = 3'd0,
    RegIntegGain = 3'd1,
    RegDerivGain = 3'd2,
    RegDeadBand  = 3'd3,
    RegSepLimit  = 3'd4,
    RegSumLimit  = 3'd5,
    RegOutLimit  = 3'd6,
    RegLeakEn    = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    StIdle,
    StLeak,
    StProp,
    StInteg,
    StDeriv,
    StOut
  } state_t;

  // Multiplier handshake between sequencer and serial unit.
  typedef struct packed {
    logic start;
    logic busy;
  } mul_ctl_t;

endpackage

// File: hdl/pid_controller_clamped.sv
// Clamped positional PID controller top level.
// Usage: feed setpoint/feedback items on the s_axis channel; each accepted
// item yields one item on m_axis carrying drive and the dead-banded error.
// Configuration writes go through cfg_wen/cfg_index/cfg_data while idle.
// Arithmetic runs through one bit-serial 33x33 multiplier; each product
// state launches it, waits through its shift-add steps and then takes
// the completion. Each item needs three products (proportional,
// integral, derivative) plus a fourth for the leak when it is enabled.
// The result goes to the output register after StOut. An item is taken
// only when the previous one has been fully processed, so a new item is
// not taken while one is still in work.
// The result sits in an output register; a new item may be accepted while
// it waits, but its result is held back until the old one is taken, and
// the input stalls until then.
// Reset (rst, synchronous) clears the error sum, previous error, the
// registers to their defaults and empties the output register.
// A stalled receiver holds tdata/tvalid steady.
module pid_controller_clamped #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // setpoint[31:0], feedback[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // drive[31:0], error_value[63:32]
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic signed [31:0] prop_gain, integ_gain, deriv_gain;
  logic [30:0] dead_band, sep_limit, sum_limit, out_limit;
  logic        leak_en;
  logic signed [31:0] error_sum, prev_error;
  logic signed [33:0] slim;
  logic signed [67:0] olim;

  pidc_pkg::state_t state, state_next;
  logic signed [31:0] err;
  logic signed [33:0] sum_w;
  logic signed [67:0] total;
  logic               pend;     // finished result waiting for output reg
  logic signed [31:0] res_drive, res_err;
  logic               go;

  logic               mstart;
  logic signed [32:0] mcand;
  logic        [32:0] mplier;
  pidc_pkg::mul_ctl_t mctl;
  logic signed [65:0] prod;
  logic               mul_done;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain <= '0; integ_gain <= '0; deriv_gain <= '0; dead_band <= '0;
      sep_limit <= '1; sum_limit <= '1; out_limit <= '1; leak_en <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_index)
        pidc_pkg::RegPropGain:  prop_gain  <= cfg_data;
        pidc_pkg::RegIntegGain: integ_gain <= cfg_data;
        pidc_pkg::RegDerivGain: deriv_gain <= cfg_data;
        pidc_pkg::RegDeadBand:  dead_band  <= cfg_data[30:0];
        pidc_pkg::RegSepLimit:  sep_limit  <= cfg_data[30:0];
        pidc_pkg::RegSumLimit:  sum_limit  <= cfg_data[30:0];
        pidc_pkg::RegOutLimit:  out_limit  <= cfg_data[30:0];
        pidc_pkg::RegLeakEn:    leak_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Limits as positive signed values for the clamps.
  assign slim = signed'(34'(sum_limit));
  assign olim = signed'(68'(out_limit));

  // Error front end, computed on the input item.
  logic signed [32:0] diff;
  logic signed [31:0] esat, edb;
  logic        [31:0] emag;
  logic signed [33:0] sum_add;
  always_comb begin
    diff = 33'(signed'(s_axis_tdata[31:0])) - 33'(signed'(s_axis_tdata[63:32]));
    if (diff > 33'sh07FFFFFFF) esat = 32'sh7FFFFFFF;
    else if (diff < -33'sh080000000) esat = 32'sh80000000;
    else esat = diff[31:0];
    emag = esat[31] ? 32'(-33'(esat)) : 32'(esat);
    edb  = (emag <= {1'b0, dead_band}) ? 32'sd0 : esat;
    emag = (emag <= {1'b0, dead_band}) ? 32'd0 : emag;
    sum_add = 34'(error_sum) + ((emag < {1'b0, sep_limit}) ? 34'(edb) : 34'sd0);
  end

  assign go = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == pidc_pkg::StIdle) && !pend;

  pidc_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .mcand(mcand), .mplier(mplier),
    .ctl(mctl), .product(prod)
  );

  logic busy_q;
  always_ff @(posedge clk) begin
    if (rst) busy_q <= 1'b0;
    else busy_q <= mctl.busy;
  end
  assign mul_done = busy_q && !mctl.busy;

  logic [33:0] smag;
  logic signed [33:0] sum_cl;
  logic signed [67:0] term;
  always_comb begin
    smag = sum_w[33] ? 34'(-sum_w) : sum_w;
    // floor shift of product
    term = 68'(prod) >>> FRAC_BITS;
    if (sum_w > slim) sum_cl = slim;
    else if (sum_w < -slim) sum_cl = -slim;
    else sum_cl = sum_w;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      pidc_pkg::StIdle:  if (go) state_next = pidc_pkg::StLeak;
      pidc_pkg::StLeak:  if (!leak_en || mul_done) state_next = pidc_pkg::StProp;
      pidc_pkg::StProp:  if (mul_done) state_next = pidc_pkg::StInteg;
      pidc_pkg::StInteg: if (mul_done) state_next = pidc_pkg::StDeriv;
      pidc_pkg::StDeriv: if (mul_done) state_next = pidc_pkg::StOut;
      pidc_pkg::StOut:   state_next = pidc_pkg::StIdle;
      default:           state_next = pidc_pkg::StIdle;
    endcase
  end

  // Multiplier launch: start on entry to each product state.
  always_comb begin
    mstart = 1'b0;
    mcand  = '0;
    mplier = '0;
    case (state)
      pidc_pkg::StLeak: begin
        mstart = leak_en && !mctl.busy && !busy_q;
        mcand  = 33'(smag[32:0]);
        mplier = 33'(pidc_pkg::LeakNum);
      end
      pidc_pkg::StProp: begin
        mstart = !mctl.busy && !busy_q;
        mcand  = 33'(prop_gain);
        mplier = 33'(err);
      end
      pidc_pkg::StInteg: begin
        mstart = !mctl.busy && !busy_q;
        mcand  = 33'(integ_gain);
        mplier = 33'(error_sum);
      end
      pidc_pkg::StDeriv: begin
        mstart = !mctl.busy && !busy_q;
        mcand  = 33'(deriv_gain);
        mplier = 33'(err) - 33'(prev_error);
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pidc_pkg::StIdle;
      error_sum  <= '0;
      prev_error <= '0;
      pend       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (go) begin
        err   <= edb;
        sum_w <= sum_add;
        total <= '0;
      end
      case (state)
        pidc_pkg::StLeak: begin
          if (!leak_en) error_sum <= sum_cl[31:0];
          else if (mul_done) begin
            if (sum_w[33]) begin
              sum_w <= -34'(prod >>> pidc_pkg::LeakShift);
              error_sum <= 32'(-34'(prod >>> pidc_pkg::LeakShift) < -slim
                ? -slim : -34'(prod >>> pidc_pkg::LeakShift));
            end else begin
              sum_w <= 34'(prod >>> pidc_pkg::LeakShift);
              error_sum <= 32'(34'(prod >>> pidc_pkg::LeakShift) > slim
                ? slim : 34'(prod >>> pidc_pkg::LeakShift));
            end
          end
        end
        pidc_pkg::StProp, pidc_pkg::StInteg, pidc_pkg::StDeriv:
          if (mul_done) total <= total + term;
        pidc_pkg::StOut: begin
          if (total > olim) res_drive <= 32'(out_limit);
          else if (total < -olim) res_drive <= -32'(out_limit);
          else res_drive <= total[31:0];
          res_err    <= err;
          prev_error <= err;
          pend       <= 1'b1;
        end
        default: ;
      endcase
      // Load the output register or drop a taken item.
      if (pend && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tdata  <= {res_err, res_drive};
        m_axis_tvalid <= 1'b1;
        pend          <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Checks.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != pidc_pkg::StIdle) |-> !s_axis_tready) else $error("accept while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("output dropped");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    (state == pidc_pkg::StOut) |=> pend) else $error("result lost");

endmodule

// File: hdl/pidc_mul.sv
// Bit-serial signed multiplier, one multiplier bit per cycle.
module pidc_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [32:0]          mcand,
  input  logic        [32:0]          mplier,
  output pidc_pkg::mul_ctl_t          ctl,
  output logic signed [65:0]          product
);

  logic signed [65:0] acc;
  logic        [32:0] mq;
  logic signed [32:0] md;
  logic        [5:0]  cnt;
  logic               busy;

  // Shift-and-add; the top multiplier bit carries negative weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd0;
      acc  <= '0;
      mq   <= mplier;
      md   <= mcand;
    end else if (busy) begin
      if (mq[0]) begin
        if (cnt == 6'd32) acc <= acc - (66'(md) <<< cnt);
        else acc <= acc + (66'(md) <<< cnt);
      end
      mq  <= mq >> 1;
      cnt <= cnt + 6'd1;
      if (cnt == 6'd32) busy <= 1'b0;
    end
  end

  assign product   = acc;
  assign ctl.start = start;
  assign ctl.busy  = busy;

endmodule

// File: tb/pidc_checker.sv
// Checker for the clamped PID controller: predicts each result and compares.
`timescale 1ns / 100ps

module pidc_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic signed [31:0] drive;
    logic signed [31:0] err;
  } pid_out_t;

  // Shadow registers and loop state
  logic signed [31:0] kp, ki, kd;
  logic [30:0] band, sep_lim, sum_lim, out_lim;
  logic leak_en;
  logic signed [31:0] err_sum, prev_err;
  pid_out_t drive_q[$];

  function automatic longint floor_shift(longint x);
    return x >>> FRAC_BITS;
  endfunction

  function automatic longint abs64(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint clamp64(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Advance the predicted loop state by one sample
  task automatic compute_drive(input logic [63:0] d);
    longint sp, fb, e, s, u, m;
    pid_out_t r;
    sp = longint'($signed(d[31:0]));
    fb = longint'($signed(d[63:32]));
    e = sp - fb;
    if (e > 64'sd2147483647) e = 64'sd2147483647;
    if (e < -64'sd2147483648) e = -64'sd2147483648;
    if (abs64(e) <= longint'(band)) e = 0;
    s = err_sum;
    if (abs64(e) < longint'(sep_lim)) s = s + e;
    if (leak_en) begin
      m = (abs64(s) * 64881) >> 16;
      s = s < 0 ? -m : m;
    end
    s = clamp64(s, longint'(sum_lim));
    u = floor_shift(longint'(kp) * e) + floor_shift(longint'(ki) * s)
      + floor_shift(longint'(kd) * (e - longint'(prev_err)));
    u = clamp64(u, longint'(out_lim));
    err_sum = s[31:0];
    prev_err = e[31:0];
    r.drive = u[31:0];
    r.err = e[31:0];
    drive_q.push_back(r);
  endtask

  always @(posedge clk) begin
    pid_out_t exp_r;
    int nerr;
    nerr = 0;
    if (rst) begin
      kp <= 0; ki <= 0; kd <= 0; band <= 0;
      sep_lim <= '1; sum_lim <= '1; out_lim <= '1; leak_en <= 0;
      err_sum = 0; prev_err = 0;
      drive_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // Track register writes
      if (cfg_wen) begin
        case (pidc_pkg::reg_index_t'(cfg_index))
          pidc_pkg::RegPropGain:  kp <= cfg_data;
          pidc_pkg::RegIntegGain: ki <= cfg_data;
          pidc_pkg::RegDerivGain: kd <= cfg_data;
          pidc_pkg::RegDeadBand:  band <= cfg_data[30:0];
          pidc_pkg::RegSepLimit:  sep_lim <= cfg_data[30:0];
          pidc_pkg::RegSumLimit:  sum_lim <= cfg_data[30:0];
          pidc_pkg::RegOutLimit:  out_lim <= cfg_data[30:0];
          pidc_pkg::RegLeakEn:    leak_en <= cfg_data[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) compute_drive(s_axis_tdata);
      // Compare each result item with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected result drive=%h err=%h", $time,
                   m_axis_tdata[31:0], m_axis_tdata[63:32]);
          nerr = nerr + 1;
        end else begin
          exp_r = drive_q.pop_front();
          if (exp_r.drive !== m_axis_tdata[31:0]) begin
            $display("%0t: drive expected %h actual %h", $time, exp_r.drive,
                     m_axis_tdata[31:0]);
            nerr = nerr + 1;
          end
          if (exp_r.err !== m_axis_tdata[63:32]) begin
            $display("%0t: error_value expected %h actual %h", $time, exp_r.err,
                     m_axis_tdata[63:32]);
            nerr = nerr + 1;
          end
        end
      end
      fail_count <= fail_count + nerr;
      pending <= drive_q.size();
    end
  end

endmodule

// File: tb/tb.sv
// Testbench top for the clamped PID controller: stimulus, pacing and verdict.
`timescale 1ns / 100ps

module tb;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        cfg_wen;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          fail_count, pending;
  logic        calm;       // no idling on either side
  logic        stall_req;  // ask the receiver for its long hold-off

  pid_controller_clamped #(.FRAC_BITS(16)) u_dut (.*);

  pidc_checker #(.FRAC_BITS(16)) u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random stalls, a calm stretch and one long hold-off
  initial begin
    int left;
    bit used;
    left = 0;
    used = 0;
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (stall_req && !used) begin
        left = 800;
        used = 1;
      end
      if (left > 0) begin
        left = left - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  task automatic write_reg(input pidc_pkg::reg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wen <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 0;
  endtask

  // Offer one item, with a random gap first unless calm
  task automatic send_sample(input logic [31:0] sp, input logic [31:0] fb);
    while (!calm && $urandom_range(99) < 29) begin
      @(posedge clk);
      s_axis_tvalid <= 0;
    end
    @(posedge clk);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {fb, sp};
    do @(posedge clk); while (!s_axis_tready);
    s_axis_tvalid <= 0;
  endtask

  task automatic drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      1: return $urandom_range(2000) - 1000;
      2: return ($urandom_range(400) - 200) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_lim();
    case ($urandom_range(3))
      0: return 32'h7FFFFFFF;
      1: return 0;
      2: return $urandom_range(50) << 16;
      default: return $urandom & 32'h7FFFFFFF;
    endcase
  endfunction

  // Random setting of every register
  task automatic set_random_cfg;
    write_reg(pidc_pkg::RegPropGain, $urandom_range(1) ? rand_val() : $urandom);
    write_reg(pidc_pkg::RegIntegGain,
              $urandom_range(1) ? ($urandom_range(8000) - 4000) : $urandom);
    write_reg(pidc_pkg::RegDerivGain, rand_val());
    write_reg(pidc_pkg::RegDeadBand,
              $urandom_range(2) ? $urandom_range(5000) : rand_lim());
    write_reg(pidc_pkg::RegSepLimit, rand_lim());
    write_reg(pidc_pkg::RegSumLimit, rand_lim());
    write_reg(pidc_pkg::RegOutLimit, rand_lim());
    write_reg(pidc_pkg::RegLeakEn, $urandom_range(1));
  endtask

  initial begin
    logic [31:0] sp;
    rst = 1; s_axis_tvalid = 0; s_axis_tdata = 0;
    cfg_wen = 0; cfg_index = 0; cfg_data = 0;
    calm = 0; stall_req = 0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed: gains +1, +1, -1, extremes of the inputs, error saturation
    write_reg(pidc_pkg::RegPropGain, 32'h00010000);
    write_reg(pidc_pkg::RegIntegGain, 32'h00010000);
    write_reg(pidc_pkg::RegDerivGain, 32'hFFFF0000);
    send_sample(32'h7FFFFFFF, 32'h80000000);
    send_sample(32'h80000000, 32'h7FFFFFFF);
    send_sample(32'h80000000, 32'h00000000);
    send_sample(32'h00000000, 32'h80000000);
    send_sample(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_sample(32'hFFFFFFFF, 32'h00000000);
    drain();
    // Dead band, separation, leak decay, tight clamps
    write_reg(pidc_pkg::RegDeadBand, 32'd100);
    write_reg(pidc_pkg::RegSepLimit, 32'd1000);
    write_reg(pidc_pkg::RegSumLimit, 32'd5000);
    write_reg(pidc_pkg::RegOutLimit, 32'd3000);
    write_reg(pidc_pkg::RegLeakEn, 1);
    send_sample(32'd100, 32'd0);
    send_sample(32'd101, 32'd0);
    send_sample(32'd0, 32'd999);
    send_sample(32'd1000, 32'd0);
    send_sample(32'd50, 32'd0);
    send_sample(32'd0, 32'd0);
    send_sample(32'd0, 32'd0);
    send_sample(32'h80000000, 32'h7FFFFFFF);
    drain();
    write_reg(pidc_pkg::RegPropGain, 32'h7FFFFFFF);
    write_reg(pidc_pkg::RegIntegGain, 32'h80000000);
    write_reg(pidc_pkg::RegDerivGain, 32'h7FFFFFFF);
    write_reg(pidc_pkg::RegSumLimit, 32'h7FFFFFFF);
    write_reg(pidc_pkg::RegOutLimit, 32'd0);
    write_reg(pidc_pkg::RegLeakEn, 0);
    send_sample(32'h12345678, 32'h87654321);
    send_sample(32'h7FFFFFFF, 32'h80000000);
    drain();
    write_reg(pidc_pkg::RegOutLimit, 32'h7FFFFFFF);
    write_reg(pidc_pkg::RegSepLimit, 32'h7FFFFFFF);
    write_reg(pidc_pkg::RegDeadBand, 32'd0);
    send_sample(32'h7FFFFFFF, 32'h80000000);
    send_sample(32'h80000000, 32'h7FFFFFFF);
    drain();

    // Random phases, each with a fresh setting
    for (int ph = 0; ph < 17; ph++) begin
      set_random_cfg();
      calm = (ph == 3);
      if (ph == 5) stall_req = 1;
      for (int i = 0; i < 100; i++) begin
        sp = rand_val();
        send_sample(sp, $urandom_range(3) == 0 ? rand_val() : sp - (rand_val() >>> 8));
      end
      // pause until every result has come
      drain();
    end
    calm = 0;
    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/pidc_pkg.sv
hdl/pidc_mul.sv
hdl/pid_controller_clamped.sv
tb/pidc_checker.sv
tb/tb.sv
